// ===== hw/rtl/rvp_pkg.sv =====
package rvp_pkg;

	localparam int SAMPLE_W = 16;
	localparam int CELLS = 16;
	localparam logic [31:0] Q30_ONE = 32'h4000_0000;

	typedef struct packed {
		logic vld;
		logic mode;
		logic signed [15:0] a;
		logic signed [15:0] b;
		logic signed [15:0] z;
		logic neg_x;
		logic neg_y;
		logic [31:0] den;
		logic [31:0] rem_x;
		logic [31:0] rem_y;
		logic [15:0] lo_x;
		logic [15:0] lo_y;
		logic [31:0] sq_v;
		logic [17:0] sq_rem;
		logic [15:0] sq_root;
	} cell_t;

	// low SAMPLE_W bits of the word to Q1.15
	function automatic logic signed [15:0] to_q15(input logic [15:0] w);
		logic [15:0] r;
		r = w << (16 - SAMPLE_W);
		return $signed({~r[15], r[14:0]});
	endfunction

	function automatic logic signed [15:0] sat_q15(input logic neg, input logic [16:0] q);
		logic [16:0] n;
		n = (~q) + 17'd1;
		if (!neg) begin
			return (q >= 17'd32767) ? 16'sh7fff : $signed(q[15:0]);
		end
		return (q >= 17'd32768) ? 16'sh8000 : $signed(n[15:0]);
	endfunction

endpackage

// ===== hw/rtl/random_unit_vector_picker_core.sv =====
// channel | handshake             | payload
// in      | in_valid / in_ready   | first_uniform, second_uniform
// out     | out_valid / out_ready | coord_x, coord_y, coord_z
// cfg     | cfg_write             | cfg_data (sphere_mode)
// One item per cycle. Pipeline: 3 setup stages, 16 cells each
// doing one divide bit (x, y) and one square root bit, 1 scaling stage,
// output register. Rejected pairs leave a bubble. The whole pipe stalls
// while the output register holds an untaken item. Reset clears valids
// and sphere_mode.
module random_unit_vector_picker_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        first_uniform,
	input  logic [15:0]        second_uniform,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] coord_x,
	output logic signed [15:0] coord_y,
	output logic signed [15:0] coord_z,
	input  logic               cfg_write,
	input  logic               cfg_data
);
	import rvp_pkg::*;

	logic en, mode_q;
	logic vld_s1, vld_s2, vld_s3, vld_s5;
	logic mode_s1, mode_s2, mode_s3, mode_s5;
	logic signed [15:0] a_s1, b_s1, a_s2, b_s2, a_s3, b_s3;
	logic signed [31:0] aa_s2, bb_s2, ab_s2, xn_s3;
	logic signed [32:0] yn_s3;
	logic [31:0] s_s3;
	cell_t pre;
	cell_t chain [CELLS+1];
	logic [31:0] mx, my, zm;
	logic signed [32:0] zn;
	logic [31:0] ssum;
	logic signed [32:0] px_s5, py_s5;
	logic signed [15:0] z_s5;
	logic nx_s5, ny_s5;
	logic [15:0] qx_s5, qy_s5;
	logic [32:0] amx, amy;
	logic [16:0] sqx, sqy;

	assign en = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_write) begin
			mode_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s5 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s5 <= chain[CELLS].vld;
			out_valid <= vld_s5;
		end
	end

	assign ssum = 32'(aa_s2) + 32'(bb_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= to_q15(first_uniform);
			b_s1 <= to_q15(second_uniform);
			mode_s1 <= mode_q;
			aa_s2 <= a_s1 * a_s1;
			bb_s2 <= b_s1 * b_s1;
			ab_s2 <= a_s1 * b_s1;
			a_s2 <= a_s1;
			b_s2 <= b_s1;
			mode_s2 <= mode_s1;
			s_s3 <= ssum;
			xn_s3 <= aa_s2 - bb_s2;
			yn_s3 <= {ab_s2, 1'b0};
			a_s3 <= a_s2;
			b_s3 <= b_s2;
			mode_s3 <= mode_s2;
		end
	end

	// cell preload: rem = N >> 16, lo = N[15:0], N = mag * 2^16 + s, D = 2s
	always_comb begin
		mx = xn_s3[31] ? 32'(-xn_s3) : 32'(xn_s3);
		my = yn_s3[32] ? 32'(-yn_s3) : yn_s3[31:0];
		zn = $signed({1'b0, Q30_ONE}) - $signed({s_s3, 1'b0});
		zm = zn[32] ? 32'(-zn) : zn[31:0];
		pre.vld = vld_s3 && (s_s3 != 32'd0) && (s_s3 <= Q30_ONE);
		pre.mode = mode_s3;
		pre.a = a_s3;
		pre.b = b_s3;
		pre.z = sat_q15(zn[32], 17'((zm + 32'd16384) >> 15));
		pre.neg_x = xn_s3[31];
		pre.neg_y = yn_s3[32];
		pre.den = {s_s3[30:0], 1'b0};
		pre.rem_x = mx + {16'd0, s_s3[31:16]};
		pre.rem_y = my + {16'd0, s_s3[31:16]};
		pre.lo_x = s_s3[15:0];
		pre.lo_y = s_s3[15:0];
		pre.sq_v = Q30_ONE - s_s3;
		pre.sq_rem = '0;
		pre.sq_root = '0;
	end

	assign chain[0] = pre;

	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		rvp_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.d(chain[i]),
			.q(chain[i+1])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s5 <= chain[CELLS].mode;
			px_s5 <= chain[CELLS].a * $signed({1'b0, chain[CELLS].sq_root});
			py_s5 <= chain[CELLS].b * $signed({1'b0, chain[CELLS].sq_root});
			z_s5 <= chain[CELLS].z;
			nx_s5 <= chain[CELLS].neg_x;
			ny_s5 <= chain[CELLS].neg_y;
			qx_s5 <= chain[CELLS].lo_x;
			qy_s5 <= chain[CELLS].lo_y;
		end
	end

	always_comb begin
		amx = px_s5[32] ? 33'(-px_s5) : 33'(px_s5);
		amy = py_s5[32] ? 33'(-py_s5) : 33'(py_s5);
		sqx = 17'((amx + 33'd8192) >> 14);
		sqy = 17'((amy + 33'd8192) >> 14);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (mode_s5) begin
				coord_x <= sat_q15(px_s5[32], sqx);
				coord_y <= sat_q15(py_s5[32], sqy);
				coord_z <= z_s5;
			end else begin
				coord_x <= sat_q15(nx_s5, {1'b0, qx_s5});
				coord_y <= sat_q15(ny_s5, {1'b0, qy_s5});
				coord_z <= '0;
			end
		end
	end

endmodule

// ===== hw/rtl/rvp_cell.sv =====
module rvp_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  rvp_pkg::cell_t d,
	output rvp_pkg::cell_t q
);
	import rvp_pkg::*;

	cell_t nx;
	cell_t data_q;
	logic vld_q;
	logic [32:0] rx, ry;
	logic [19:0] sr, st;

	always_comb begin
		nx = d;
		rx = {d.rem_x, d.lo_x[15]};
		ry = {d.rem_y, d.lo_y[15]};
		if (rx >= {1'b0, d.den}) begin
			nx.rem_x = 32'(rx - {1'b0, d.den});
			nx.lo_x = {d.lo_x[14:0], 1'b1};
		end else begin
			nx.rem_x = rx[31:0];
			nx.lo_x = {d.lo_x[14:0], 1'b0};
		end
		if (ry >= {1'b0, d.den}) begin
			nx.rem_y = 32'(ry - {1'b0, d.den});
			nx.lo_y = {d.lo_y[14:0], 1'b1};
		end else begin
			nx.rem_y = ry[31:0];
			nx.lo_y = {d.lo_y[14:0], 1'b0};
		end
		sr = {d.sq_rem, d.sq_v[31:30]};
		st = {2'b00, d.sq_root, 2'b01};
		nx.sq_v = {d.sq_v[29:0], 2'b00};
		if (sr >= st) begin
			nx.sq_rem = 18'(sr - st);
			nx.sq_root = {d.sq_root[14:0], 1'b1};
		end else begin
			nx.sq_rem = sr[17:0];
			nx.sq_root = {d.sq_root[14:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= d.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nx;
		end
	end

	always_comb begin
		q = data_q;
		q.vld = vld_q;
	end

endmodule

// ===== hw/rtl/rvp_checker.sv =====
module rvp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] coord_x,
	input logic signed [15:0] coord_y,
	input logic signed [15:0] coord_z
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(coord_x) && $stable(coord_y)
		&& $stable(coord_z))
		else $error("output item changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("ready does not follow output stall");

	a_rst: assert property (@(posedge clk) $rose(arst_n) |-> !out_valid)
		else $error("item present out of reset");

	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

endmodule

bind random_unit_vector_picker_core rvp_checker u_rvp_checker (.*);
